[design/quaternion_to_euler_zyx_core_macros.svh]
// Assertion macros for the quaternion to Euler angle core
`ifndef QUATERNION_TO_EULER_ZYX_CORE_MACROS_SVH
`define QUATERNION_TO_EULER_ZYX_CORE_MACROS_SVH

// condition holds in the same cycle
`define Q2E_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the following cycle
`define Q2E_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/q2e_pkg.sv]
// Shared types, widths and tables for the quaternion to Euler angle core
`timescale 1ns / 1ps

package q2e_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;
    localparam int OP_W             = 35;   // atan2 operand width
    localparam int CORD_W           = 37;   // CORDIC x/y width, allows gain growth
    localparam int ANG_W            = 34;   // angle accumulator, 2^31 = pi
    localparam int SQ_W             = 57;   // radicand, up to 2^56
    localparam int ROOT_W           = 29;   // root, up to 2^28
    localparam int T_W              = 30;   // clamped pitch test
    localparam int MAG_W            = 29;
    localparam int PROD_W           = 32;
    localparam int LIM_W            = 15;
    localparam int BAM_W            = 16;

    localparam logic [LIM_W-1:0] GIMBAL_LIMIT_RST = LIM_W'(16384);

    localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_q2e_in;

    typedef struct packed {
        logic signed [15:0] roll_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] yaw_angle;
        logic               gimbal_case;
    } t_q2e_out;

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [ANG_W-1:0]  z;
        logic                     zero;
    } t_cordic;

    typedef struct packed {
        logic [SQ_W-1:0]       rem;
        logic [ROOT_W-1:0]     root;
        logic signed [T_W-1:0] t;
    } t_sqrt;

    typedef struct packed {
        logic [BAM_W-1:0] roll;
        logic [BAM_W-1:0] yaw;
    } t_angles;

endpackage

[design/q2e_sqrt_cell.sv]
// One root bit of the restoring square root chain
`timescale 1ns / 1ps

module q2e_sqrt_cell #(
    parameter int K = 0
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  q2e_pkg::t_sqrt i_cell,
    output q2e_pkg::t_sqrt o_cell
);

    localparam int TW = q2e_pkg::SQ_W + 2;

    logic [TW-1:0]      w_test;
    logic [TW-1:0]      w_rem;
    q2e_pkg::t_sqrt     n_cell;
    q2e_pkg::t_sqrt     r_cell;

    // test = 2*root*2^K + 4^K, root holds only bits above K
    assign w_test = (TW'(i_cell.root) << (K + 1)) + (TW'(1) << (2 * K));
    assign w_rem  = TW'(i_cell.rem);

    always_comb begin
        n_cell = i_cell;
        if (w_rem >= w_test) begin
            n_cell.rem  = i_cell.rem - w_test[q2e_pkg::SQ_W-1:0];
            n_cell.root = i_cell.root | (q2e_pkg::ROOT_W'(1) << K);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

[design/q2e_cordic_cell.sv]
// One vectoring CORDIC iteration
`timescale 1ns / 1ps

module q2e_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  q2e_pkg::t_cordic i_cell,
    output q2e_pkg::t_cordic o_cell
);

    logic signed [q2e_pkg::CORD_W-1:0] w_dx;
    logic signed [q2e_pkg::CORD_W-1:0] w_dy;
    logic signed [q2e_pkg::ANG_W-1:0]  w_da;
    q2e_pkg::t_cordic                  n_cell;
    q2e_pkg::t_cordic                  r_cell;

    assign w_dx = $signed(i_cell.y) >>> IDX;
    assign w_dy = $signed(i_cell.x) >>> IDX;
    assign w_da = $signed(q2e_pkg::ANG_W'(q2e_pkg::ATAN_TAB[IDX]));

    always_comb begin
        n_cell = i_cell;
        if (!i_cell.y[q2e_pkg::CORD_W-1]) begin
            n_cell.x = i_cell.x + w_dx;
            n_cell.y = i_cell.y - w_dy;
            n_cell.z = i_cell.z + w_da;
        end else begin
            n_cell.x = i_cell.x - w_dx;
            n_cell.y = i_cell.y + w_dy;
            n_cell.z = i_cell.z - w_da;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cell <= n_cell;
        end
    end

    assign o_cell = r_cell;

endmodule

[design/q2e_atan2.sv]
// atan2 as a row of CORDIC cells, result as a 16-bit binary angle
`timescale 1ns / 1ps

module q2e_atan2 #(
    parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [q2e_pkg::OP_W-1:0]  i_y,
    input  logic signed [q2e_pkg::OP_W-1:0]  i_x,
    output logic [q2e_pkg::BAM_W-1:0]        o_angle
);

    localparam int N = (CORDIC_STEPS < q2e_pkg::ATAN_LEN) ? CORDIC_STEPS : q2e_pkg::ATAN_LEN;
    localparam logic signed [q2e_pkg::ANG_W-1:0] PI_ACC = q2e_pkg::ANG_W'(64'sd1 <<< 31);

    q2e_pkg::t_cordic n_pre;
    q2e_pkg::t_cordic r_pre;
    q2e_pkg::t_cordic w_chain [N+1];
    logic signed [q2e_pkg::CORD_W-1:0] w_x;
    logic signed [q2e_pkg::CORD_W-1:0] w_y;
    logic signed [q2e_pkg::ANG_W-1:0]  w_rnd;

    assign w_x = q2e_pkg::CORD_W'(i_x);
    assign w_y = q2e_pkg::CORD_W'(i_y);

    // left half-plane: turn by pi first
    always_comb begin
        n_pre.zero = (i_x == '0) && (i_y == '0);
        if (i_x < 0) begin
            n_pre.x = -w_x;
            n_pre.y = -w_y;
            n_pre.z = (i_y >= 0) ? PI_ACC : -PI_ACC;
        end else begin
            n_pre.x = w_x;
            n_pre.y = w_y;
            n_pre.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre <= n_pre;
        end
    end

    assign w_chain[0] = r_pre;

    for (genvar g = 0; g < N; g++) begin : g_cell
        q2e_cordic_cell #(.IDX(g)) u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_cell (w_chain[g]),
            .o_cell (w_chain[g+1])
        );
    end

    // round half up, wrap to 16 bits
    assign w_rnd   = w_chain[N].z + q2e_pkg::ANG_W'(32768);
    assign o_angle = w_chain[N].zero ? '0 : w_rnd[31:16];

endmodule

[design/quaternion_to_euler_zyx_core.sv]
// Top level: quaternion to ZYX Euler angles, fully pipelined
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------
//  in      | sink      | i_in_valid / o_in_ready | i_in_data  (t_q2e_in)
//  out     | source    | o_out_valid/i_out_ready | o_out_data (t_q2e_out)
//  cfg     | sink      | i_cfg_we                | i_cfg_data (gimbal limit)
//
// One beat accepted per cycle while the output is not stalled. The pipeline holds
// three product, sum and clamp stages, the radicand register, a 29-cell square root chain,
// one CORDIC setup stage, one CORDIC cell per step and the output register.
// Reset clears all valid bits and sets the gimbal limit to 16384.
// A stalled output beat freezes the whole pipeline; o_in_ready is low only then.
`timescale 1ns / 1ps
`include "quaternion_to_euler_zyx_core_macros.svh"

module quaternion_to_euler_zyx_core #(
    parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  q2e_pkg::t_q2e_in                i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output q2e_pkg::t_q2e_out               o_out_data,
    input  logic                            i_cfg_we,
    input  logic [q2e_pkg::LIM_W-1:0]       i_cfg_data
);

    localparam int N    = (CORDIC_STEPS < q2e_pkg::ATAN_LEN) ? CORDIC_STEPS : q2e_pkg::ATAN_LEN;
    localparam int DLY  = 1 + q2e_pkg::ROOT_W;      // square root path after stage 3
    localparam int GL   = DLY + 1 + N;              // stage 3 to output
    localparam int P    = 3 + GL;                   // pipeline stages before output
    localparam int OW   = q2e_pkg::OP_W;
    localparam int PW   = q2e_pkg::PROD_W;
    localparam int MSW  = 2 * q2e_pkg::MAG_W;
    localparam logic signed [OW-1:0] ONE = OW'(64'sd1 <<< 28);

    logic          w_en;
    logic          w_acc;
    logic [P-1:0]  r_vld;
    logic          r_out_vld;
    q2e_pkg::t_q2e_out r_out;
    logic [q2e_pkg::LIM_W-1:0] r_gimbal_limit;

    // stage 1: products
    logic signed [q2e_pkg::PROD_W-1:0] r_wy, r_xz, r_yz, r_wx, r_xx, r_yy, r_xy, r_wz, r_zz;
    // stage 2: sums
    logic signed [OW-1:0] r2_t, r2_rny, r2_rnx, r2_yy, r2_yx, r2_gy, r2_gx;
    // stage 3: clamp, gimbal test, operand select
    logic signed [OW-1:0] n3_t;
    logic signed [OW-1:0] n3_ry, n3_rx;
    logic [q2e_pkg::MAG_W-1:0] n3_mag;
    logic                      n3_gimbal;
    logic signed [q2e_pkg::T_W-1:0] r3_t;
    logic [q2e_pkg::MAG_W-1:0] r3_mag;
    logic signed [OW-1:0] r3_ry, r3_rx, r3_yy, r3_yx;
    logic [GL:0]          r_gim;

    q2e_pkg::t_sqrt  r4_sq;
    q2e_pkg::t_sqrt  w_sq [q2e_pkg::ROOT_W+1];
    logic [2*q2e_pkg::MAG_W-1:0] w_magsq;

    logic [q2e_pkg::BAM_W-1:0] w_roll, w_yaw, w_pitch;
    q2e_pkg::t_angles          r_dly [DLY];

    assign w_en       = !r_out_vld || i_out_ready;
    assign o_in_ready = w_en;
    assign w_acc      = i_in_valid && w_en;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld          <= '0;
            r_out_vld      <= 1'b0;
            r_gimbal_limit <= q2e_pkg::GIMBAL_LIMIT_RST;
        end else begin
            if (w_en) begin
                r_vld     <= {r_vld[P-2:0], w_acc};
                r_out_vld <= r_vld[P-1];
            end
            if (i_cfg_we) begin
                r_gimbal_limit <= i_cfg_data;
            end
        end
    end

    // stages 1 and 2
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wy <= PW'(i_in_data.quat_w) * PW'(i_in_data.quat_y);
            r_xz <= PW'(i_in_data.quat_x) * PW'(i_in_data.quat_z);
            r_yz <= PW'(i_in_data.quat_y) * PW'(i_in_data.quat_z);
            r_wx <= PW'(i_in_data.quat_w) * PW'(i_in_data.quat_x);
            r_xx <= PW'(i_in_data.quat_x) * PW'(i_in_data.quat_x);
            r_yy <= PW'(i_in_data.quat_y) * PW'(i_in_data.quat_y);
            r_xy <= PW'(i_in_data.quat_x) * PW'(i_in_data.quat_y);
            r_wz <= PW'(i_in_data.quat_w) * PW'(i_in_data.quat_z);
            r_zz <= PW'(i_in_data.quat_z) * PW'(i_in_data.quat_z);

            r2_t   <= (OW'(r_wy) - OW'(r_xz)) <<< 1;
            r2_rny <= (OW'(r_yz) + OW'(r_wx)) <<< 1;
            r2_rnx <= ONE - ((OW'(r_xx) + OW'(r_yy)) <<< 1);
            r2_yy  <= (OW'(r_xy) + OW'(r_wz)) <<< 1;
            r2_yx  <= ONE - ((OW'(r_yy) + OW'(r_zz)) <<< 1);
            r2_gy  <= (OW'(r_xy) - OW'(r_wz)) <<< 1;
            r2_gx  <= (OW'(r_xz) + OW'(r_wy)) <<< 1;
        end
    end

    // stage 3
    always_comb begin
        priority if (r2_t > ONE) begin
            n3_t = ONE;
        end else if (r2_t < -ONE) begin
            n3_t = -ONE;
        end else begin
            n3_t = r2_t;
        end
        n3_mag    = r2_t[OW-1] ? q2e_pkg::MAG_W'(-n3_t) : q2e_pkg::MAG_W'(n3_t);
        n3_gimbal = {1'b0, n3_mag} >= {1'b0, r_gimbal_limit, 14'b0};
        if (n3_gimbal) begin
            // sign of t applied to both operands
            n3_ry = r2_t[OW-1] ? -r2_gy : r2_gy;
            n3_rx = r2_t[OW-1] ? -r2_gx : r2_gx;
        end else begin
            n3_ry = r2_rny;
            n3_rx = r2_rnx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_t   <= q2e_pkg::T_W'(n3_t);
            r3_mag <= n3_mag;
            r3_ry  <= n3_ry;
            r3_rx  <= n3_rx;
            r3_yy  <= r2_yy;
            r3_yx  <= r2_yx;
            r_gim  <= {r_gim[GL-1:0], n3_gimbal};
        end
    end

    // cos(pitch) = sqrt(1 - t^2) in Q.28
    assign w_magsq = MSW'(r3_mag) * MSW'(r3_mag);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_sq.rem  <= (q2e_pkg::SQ_W'(1) << 56) - q2e_pkg::SQ_W'(w_magsq);
            r4_sq.root <= '0;
            r4_sq.t    <= r3_t;
        end
    end

    assign w_sq[0] = r4_sq;

    for (genvar g = 0; g < q2e_pkg::ROOT_W; g++) begin : g_sqrt
        q2e_sqrt_cell #(.K(q2e_pkg::ROOT_W - 1 - g)) u_sqrt (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_cell (w_sq[g]),
            .o_cell (w_sq[g+1])
        );
    end

    q2e_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (OW'(w_sq[q2e_pkg::ROOT_W].t)),
        .i_x     ($signed(OW'(w_sq[q2e_pkg::ROOT_W].root))),
        .o_angle (w_pitch)
    );

    q2e_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (r3_ry),
        .i_x     (r3_rx),
        .o_angle (w_roll)
    );

    q2e_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (r3_yy),
        .i_x     (r3_yx),
        .o_angle (w_yaw)
    );

    // roll and yaw finish ahead of pitch; hold them back by the root path
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dly[0].roll <= w_roll;
            r_dly[0].yaw  <= w_yaw;
            for (int i = 1; i < DLY; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.roll_angle  <= r_dly[DLY-1].roll;
            r_out.pitch_angle <= w_pitch;
            r_out.yaw_angle   <= r_gim[GL] ? '0 : r_dly[DLY-1].yaw;
            r_out.gimbal_case <= r_gim[GL];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `Q2E_ASSERT_NOW(a_gimbal_yaw, i_clk, i_rst_n, r_out_vld && r_out.gimbal_case, r_out.yaw_angle == '0, "yaw not zero in gimbal case")
    `Q2E_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !w_en, $stable(r_vld), "pipeline moved during stall")
    `Q2E_ASSERT_NEXT(a_last_to_out, i_clk, i_rst_n, w_en && r_vld[P-1], o_out_valid, "result beat lost at output")

endmodule

[test/tb_quaternion_to_euler_zyx_core.sv]
// Testbench for the quaternion to ZYX Euler angle core: random beats, scoreboarded
`timescale 1ns / 1ps

module tb_quaternion_to_euler_zyx_core;
    import q2e_pkg::*;

    localparam int LATENCY   = 51;
    localparam int MAX_CYC   = 400000;
    localparam longint ONE28 = 64'sd1 << 28;
    localparam longint PI31  = 64'sd1 << 31;

    class euler_board;
        t_q2e_out pending[$];
        logic [LIM_W-1:0] limit;
        int unsigned n_err;
        int unsigned n_ok;
        int unsigned n_gimbal;

        function new();
            limit = GIMBAL_LIMIT_RST;
            n_err = 0;
            n_ok = 0;
            n_gimbal = 0;
        endfunction

        function longint fshift(longint v, int s);
            return v >>> s;
        endfunction

        function longint root56(longint v);
            longint r;
            longint b;
            r = 0;
            b = 64'sd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function logic [15:0] bam_atan2(longint y, longint x);
            longint z;
            longint dx;
            longint dy;
            z = 0;
            if (x == 0 && y == 0) return 16'd0;
            if (x < 0) begin
                z = (y >= 0) ? PI31 : -PI31;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
                dx = fshift(y, i);
                dy = fshift(x, i);
                if (y >= 0) begin
                    x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
                end else begin
                    x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
                end
            end
            return 16'(fshift(z + 32768, 16));
        endfunction

        function void note_quat(t_q2e_in q);
            longint x, y, z, w, t, c, mag, s;
            t_q2e_out e;
            x = q.quat_x; y = q.quat_y; z = q.quat_z; w = q.quat_w;
            t = 2 * (w * y - x * z);
            if (t > ONE28) t = ONE28;
            if (t < -ONE28) t = -ONE28;
            c = root56((64'sd1 << 56) - t * t);
            e.pitch_angle = bam_atan2(t, c);
            mag = t < 0 ? -t : t;
            if (mag >= (longint'(limit) << 14)) begin
                s = (t >= 0) ? 1 : -1;
                e.roll_angle  = bam_atan2(s * 2 * (x * y - w * z), s * 2 * (x * z + w * y));
                e.yaw_angle   = '0;
                e.gimbal_case = 1'b1;
                n_gimbal++;
            end else begin
                e.roll_angle  = bam_atan2(2 * (y * z + w * x), ONE28 - 2 * (x * x + y * y));
                e.yaw_angle   = bam_atan2(2 * (x * y + w * z), ONE28 - 2 * (y * y + z * z));
                e.gimbal_case = 1'b0;
            end
            pending.push_back(e);
        endfunction

        function void check_angles(t_q2e_out got);
            t_q2e_out e;
            if (pending.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected beat: %p", got);
                return;
            end
            e = pending.pop_front();
            if (got.roll_angle !== e.roll_angle || got.pitch_angle !== e.pitch_angle ||
                got.yaw_angle !== e.yaw_angle || got.gimbal_case !== e.gimbal_case) begin
                n_err++;
                if (n_err <= 10)
                    $display("mismatch: exp r=%0d p=%0d y=%0d g=%0b got r=%0d p=%0d y=%0d g=%0b",
                        e.roll_angle, e.pitch_angle, e.yaw_angle, e.gimbal_case,
                        got.roll_angle, got.pitch_angle, got.yaw_angle, got.gimbal_case);
            end else begin
                n_ok++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    t_q2e_in          i_in_data;
    logic             o_out_valid;
    logic             i_out_ready;
    t_q2e_out         o_out_data;
    logic             i_cfg_we;
    logic [LIM_W-1:0] i_cfg_data;

    euler_board board;
    int unsigned cycles;
    bit calm_in;
    bit calm_out;
    bit hold_out;

    quaternion_to_euler_zyx_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // output side: sample at rising edge, change ready at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) board.check_angles(o_out_data);
    end

    initial begin
        i_out_ready = 1'b0;
        hold_out = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_out) begin
                i_out_ready <= 1'b0;
                repeat (300) @(negedge i_clk);
                hold_out = 1'b0;
            end
            i_out_ready <= calm_out ? 1'b1 : ($urandom_range(99) >= 10);
        end
    end

    // valid stays up after the beat; the next call or a drain decides what follows
    task automatic send_quat(input t_q2e_in q);
        if (!calm_in)
            while ($urandom_range(99) < 10) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        i_in_valid <= 1'b1;
        i_in_data  <= q;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_quat(q);
        @(negedge i_clk);
    endtask

    task automatic send_fields(input int x, input int y, input int z, input int w);
        t_q2e_in q;
        q.quat_x = 16'(x); q.quat_y = 16'(y); q.quat_z = 16'(z); q.quat_w = 16'(w);
        send_quat(q);
    endtask

    task automatic drain_all();
        i_in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 5) @(negedge i_clk);
    endtask

    task automatic write_limit(input int v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= LIM_W'(v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        board.limit = LIM_W'(v);
    endtask

    function automatic int rand_comp();
        return int'($urandom_range(32768)) - 16384;
    endfunction

    // random unit-ish quaternion: pick direction then normalise in real arithmetic
    task automatic send_unit();
        real a, b, c, d, n;
        a = rand_comp(); b = rand_comp(); c = rand_comp(); d = rand_comp();
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) n = 1.0;
        send_fields($rtoi(a * 16384.0 / n), $rtoi(b * 16384.0 / n),
                    $rtoi(c * 16384.0 / n), $rtoi(d * 16384.0 / n));
    endtask

    // near-gimbal: w*y - x*z close to +-0.5
    task automatic send_near_gimbal();
        int s, e;
        s = $urandom_range(1) ? 11585 : -11585;
        e = int'($urandom_range(400)) - 200;
        send_fields(e, s + e, int'($urandom_range(400)) - 200, 11585 - e);
    endtask

    task automatic random_phase(input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 70) send_unit();
            else if (k < 85) send_near_gimbal();
            else begin
                t_q2e_in q;
                q = {$urandom, $urandom};
                if ($urandom_range(3) == 0) q.quat_y = 16'($urandom_range(1) ? 16384 : -16384);
                send_quat(q);
            end
        end
    endtask

    initial begin
        board = new();
        cycles = 0;
        calm_in = 1'b0;
        calm_out = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: identity, axes, extremes, gimbal both ways, zero quaternion
        send_fields(0, 0, 0, 16384);
        send_fields(16384, 0, 0, 0);
        send_fields(0, 16384, 0, 0);
        send_fields(0, 0, 16384, 0);
        send_fields(0, 0, 0, -16384);
        send_fields(0, 0, 0, 0);
        send_fields(11585, 0, 0, 11585);
        send_fields(0, 11585, 0, 11585);
        send_fields(0, -11585, 0, 11585);
        send_fields(11585, 0, -11585, 0);
        send_fields(-16384, -16384, -16384, -16384);
        send_fields(16384, 16384, 16384, 16384);
        send_fields(16384, -16384, 16384, -16384);
        send_fields(-32768, 32767, -32768, 32767);
        send_fields(32767, -32768, 32767, -32768);
        send_fields(8192, 8192, 8192, 8192);
        send_fields(-8192, 8192, -8192, -8192);
        send_fields(0, 0, -16384, 1);
        send_fields(1, -1, 1, -1);
        send_fields(0, 16384, 16384, 0);

        random_phase(150);

        // sender pauses until everything is back, then the register is set to 0, 16383 and 32767
        drain_all();
        write_limit(0);
        random_phase(60);
        drain_all();
        write_limit(16383);
        random_phase(60);
        drain_all();
        write_limit(32767);
        random_phase(60);

        // long receiver hold-off while beats keep coming, no idling
        drain_all();
        write_limit(15000);
        calm_in = 1'b1;
        calm_out = 1'b1;
        hold_out = 1'b1;
        random_phase(150);
        calm_in = 1'b0;
        calm_out = 1'b0;
        drain_all();
        write_limit(16384);
        random_phase(150);

        drain_all();
        $display("Converted %0d quaternions (%0d in the gimbal case) across five limit settings.",
            board.n_ok + board.n_err, board.n_gimbal);
        if (board.n_err == 0 && board.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches, %0d beats outstanding", board.n_err,
                board.pending.size());
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
